/* rtl/top_n_flow_selector_macros.svh */
// Assertion macros for the top-N flow selector.
`ifndef TOP_N_FLOW_SELECTOR_MACROS_SVH
`define TOP_N_FLOW_SELECTOR_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while reset is released.
`define TNFS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tnfs: assertion failed");

// Checked at every clock edge, reset included.
`define TNFS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tnfs: assertion failed");

`else

`define TNFS_ASSERT(lbl, clk, rstn, prop)
`define TNFS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/tnfs_pkg.sv */
package tnfs_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned IdPortW   = 16;
  localparam int unsigned PktW      = 32;
  localparam int unsigned RankW     = 4;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned ModeW     = 2;

  // Upper limit on results per finish.
  localparam int unsigned MaxResults = 16;

  localparam logic [CfgW-1:0] TopCountReset = 5'd16;

  localparam logic [ModeW-1:0] MODE_OFFER        = 2'd0;
  localparam logic [ModeW-1:0] MODE_OFFER_FINISH = 2'd1;
  localparam logic [ModeW-1:0] MODE_FINISH       = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic offer;     // an entry is offered this cycle
    logic shift_up;  // drain: take the data of the next cell
    logic clear;     // final drain cycle: empty the slot
  } cell_ctrl_t;

endpackage

/* rtl/tnfs_cell.sv */
module tnfs_cell #(
  parameter int unsigned IdW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tnfs_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         active_i,
  input  logic                         found_i,
  output logic                         found_o,
  input  logic [IdW-1:0]               new_id_i,
  input  logic [tnfs_pkg::PktW-1:0]    new_pkt_i,
  input  logic [IdW-1:0]               prev_id_i,
  input  logic [tnfs_pkg::PktW-1:0]    prev_cnt_i,
  input  logic                         prev_full_i,
  input  logic [IdW-1:0]               next_id_i,
  input  logic [tnfs_pkg::PktW-1:0]    next_cnt_i,
  input  logic                         next_full_i,
  output logic [IdW-1:0]               id_o,
  output logic [tnfs_pkg::PktW-1:0]    cnt_o,
  output logic                         full_o
);
  import tnfs_pkg::*;

  logic [IdW-1:0]  id_q, id_d;
  logic [PktW-1:0] cnt_q, cnt_d;
  logic            full_q, full_d;
  logic            take;

  // The entry belongs here or earlier if this slot is empty or strictly smaller.
  assign take    = active_i && (!full_q || (new_pkt_i > cnt_q));
  assign found_o = found_i || take;

  always_comb begin
    id_d   = id_q;
    cnt_d  = cnt_q;
    full_d = full_q;
    priority if (ctrl_i.clear) begin
      full_d = 1'b0;
    end else if (ctrl_i.shift_up) begin
      id_d   = next_id_i;
      cnt_d  = next_cnt_i;
      full_d = next_full_i;
    end else if (ctrl_i.offer && active_i) begin
      if (found_i) begin
        // An earlier cell took the entry: move down one place.
        id_d   = prev_id_i;
        cnt_d  = prev_cnt_i;
        full_d = prev_full_i;
      end else if (take) begin
        id_d   = new_id_i;
        cnt_d  = new_pkt_i;
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    cnt_q <= cnt_d;
  end

  assign id_o   = id_q;
  assign cnt_o  = cnt_q;
  assign full_o = full_q;

endmodule

/* rtl/top_n_flow_selector.sv */
// Channel   Direction  Handshake               Payload
// command   in         start_i / busy_o        mode_i, flow_id_i, flow_packets_i
// result    out        result_valid_o (strobe) rank_o, ranked_flow_id_o, ranked_packets_o,
//                                              slot_valid_o, last_result_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_data_i (top_count)
//
// An offered entry is inserted in the cycle it is accepted: one entry per cycle while busy_o is low.
// A finish holds busy_o high while the clamped top_count slots drain; each drain
// cycle moves one slot out of cell 0 of the chain, and its result is on the ports
// in the next cycle. The list is cleared in the last drain cycle.
// After reset every slot is empty and top_count is 16.
// Results are strobes; the receiver cannot stall them.
`include "top_n_flow_selector_macros.svh"

module top_n_flow_selector #(
  parameter int unsigned TOP_SLOTS    = 16,
  parameter int unsigned FLOW_ID_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [tnfs_pkg::ModeW-1:0]       mode_i,
  input  logic [tnfs_pkg::IdPortW-1:0]     flow_id_i,
  input  logic [tnfs_pkg::PktW-1:0]        flow_packets_i,
  output logic                             result_valid_o,
  output logic [tnfs_pkg::RankW-1:0]       rank_o,
  output logic [tnfs_pkg::IdPortW-1:0]     ranked_flow_id_o,
  output logic [tnfs_pkg::PktW-1:0]        ranked_packets_o,
  output logic                             slot_valid_o,
  output logic                             last_result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tnfs_pkg::CfgW-1:0]        cfg_data_i
);
  import tnfs_pkg::*;

  localparam int unsigned NMax = (TOP_SLOTS < MaxResults) ? TOP_SLOTS : MaxResults;
  localparam int unsigned IdxW = 7;

  state_e state_q, state_d;

  logic [CfgW-1:0]  top_count_q;
  logic [CfgW-1:0]  act_n;
  logic [RankW-1:0] rank_q, rank_d;

  logic             accept;
  logic             do_offer;
  logic             do_finish;
  logic             drain_last;
  cell_ctrl_t       ctrl;

  logic [FLOW_ID_BITS-1:0] new_id;
  logic [IdPortW-1:0]      head_id;

  logic [FLOW_ID_BITS-1:0] cell_id   [TOP_SLOTS];
  logic [PktW-1:0]         cell_cnt  [TOP_SLOTS];
  logic                    cell_full [TOP_SLOTS];
  logic                    found     [TOP_SLOTS+1];

  logic                    out_valid_q;
  logic [RankW-1:0]        out_rank_q;
  logic [IdPortW-1:0]      out_id_q;
  logic [PktW-1:0]         out_pkt_q;
  logic                    out_full_q;
  logic                    out_last_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TopCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      top_count_q <= cfg_data_i;
    end
  end

  // Slots in use: zero acts as one, large values saturate.
  always_comb begin
    act_n = top_count_q;
    if (act_n == '0) begin
      act_n = CfgW'(1);
    end else if (act_n > CfgW'(NMax)) begin
      act_n = CfgW'(NMax);
    end
  end

  assign accept    = start_i && !busy_o;
  assign do_offer  = accept && ((mode_i == MODE_OFFER) || (mode_i == MODE_OFFER_FINISH));
  assign do_finish = accept && ((mode_i == MODE_FINISH) || (mode_i == MODE_OFFER_FINISH));
  assign drain_last = ({1'b0, rank_q} == (act_n - CfgW'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_finish) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    busy_o        = 1'b0;
    ctrl.offer    = 1'b0;
    ctrl.shift_up = 1'b0;
    ctrl.clear    = 1'b0;
    rank_d        = rank_q;
    unique case (state_q)
      ST_IDLE: begin
        ctrl.offer = do_offer;
        rank_d     = '0;
      end
      ST_DRAIN: begin
        busy_o        = 1'b1;
        ctrl.clear    = drain_last;
        ctrl.shift_up = !drain_last;
        rank_d        = rank_q + RankW'(1);
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

  // Identifier width conversions between the ports and the cells.
  generate
    if (FLOW_ID_BITS <= IdPortW) begin : g_id_narrow
      assign new_id  = flow_id_i[FLOW_ID_BITS-1:0];
      assign head_id = IdPortW'(cell_id[0]);
    end else begin : g_id_wide
      assign new_id  = FLOW_ID_BITS'(flow_id_i);
      assign head_id = cell_id[0][IdPortW-1:0];
    end
  endgenerate

  assign found[0] = 1'b0;

  generate
    for (genvar i = 0; i < TOP_SLOTS; i++) begin : g_cell
      logic                    active;
      logic [FLOW_ID_BITS-1:0] prev_id, next_id;
      logic [PktW-1:0]         prev_cnt, next_cnt;
      logic                    prev_full, next_full;

      assign active = (IdxW'(i) < IdxW'(act_n));

      if (i == 0) begin : g_first
        assign prev_id   = '0;
        assign prev_cnt  = '0;
        assign prev_full = 1'b0;
      end else begin : g_mid
        assign prev_id   = cell_id[i-1];
        assign prev_cnt  = cell_cnt[i-1];
        assign prev_full = cell_full[i-1];
      end

      if (i == TOP_SLOTS - 1) begin : g_last
        assign next_id   = '0;
        assign next_cnt  = '0;
        assign next_full = 1'b0;
      end else begin : g_inner
        assign next_id   = cell_id[i+1];
        assign next_cnt  = cell_cnt[i+1];
        assign next_full = cell_full[i+1];
      end

      tnfs_cell #(
        .IdW (FLOW_ID_BITS)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .active_i    (active),
        .found_i     (found[i]),
        .found_o     (found[i+1]),
        .new_id_i    (new_id),
        .new_pkt_i   (flow_packets_i),
        .prev_id_i   (prev_id),
        .prev_cnt_i  (prev_cnt),
        .prev_full_i (prev_full),
        .next_id_i   (next_id),
        .next_cnt_i  (next_cnt),
        .next_full_i (next_full),
        .id_o        (cell_id[i]),
        .cnt_o       (cell_cnt[i]),
        .full_o      (cell_full[i])
      );
    end
  endgenerate

  // Result register, loaded from the head of the chain while draining.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (state_q == ST_DRAIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      out_rank_q <= rank_q;
      out_id_q   <= cell_full[0] ? head_id : '0;
      out_pkt_q  <= cell_full[0] ? cell_cnt[0] : '0;
      out_full_q <= cell_full[0];
      out_last_q <= drain_last;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign rank_o           = out_rank_q;
  assign ranked_flow_id_o = out_id_q;
  assign ranked_packets_o = out_pkt_q;
  assign slot_valid_o     = out_full_q;
  assign last_result_o    = out_last_q;

  // A finish request always starts a drain.
  `TNFS_ASSERT(a_finish_drains, clk_i, rst_ni, do_finish |=> busy_o)
  // The first result of every drain is rank zero.
  `TNFS_ASSERT(a_first_rank, clk_i, rst_ni, $rose(busy_o) |=> (result_valid_o && (rank_o == '0)))
  // Once the block is free again, only the final result can still be showing.
  `TNFS_ASSERT_ALWAYS(a_idle_last, clk_i, (result_valid_o && !busy_o) |-> last_result_o)

endmodule
